FILE: src/assert_macros.svh
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next cycle check failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALL(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("next cycle check failed");

`endif

FILE: src/smc_pkg.sv
`default_nettype none

package smc_pkg;

  localparam int BYTE_W      = 8;
  localparam int NEEDLE_W    = 64;
  localparam int LEN_W       = 4;
  localparam int COUNT_W     = 16;
  localparam int FIELD_W     = 17;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_PAY_W   = COUNT_W + 2 * FIELD_W + 1;
  localparam int OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_PAY_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;
  localparam logic [FIELD_W-1:0] FIELD_POS_MAX = 17'h0FFFF;
  localparam logic [FIELD_W-1:0] NONE_POS      = 17'h1FFFF;

  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LEN   = 1'b1;

  // needle as seen by every cell, length already clamped
  typedef struct packed {
    logic [NEEDLE_W-1:0] bytes;
    logic [LEN_W-1:0]    len;
  } needle_cfg_t;

endpackage

`default_nettype wire

FILE: src/smc_cell.sv
`default_nettype none

module smc_cell #(
  parameter int IDX = 0
) (
  input  wire logic                      clk,
  input  wire logic                      shift,
  input  wire logic [smc_pkg::BYTE_W-1:0] byte_in,
  input  wire smc_pkg::needle_cfg_t      ncfg,
  output logic [smc_pkg::BYTE_W-1:0]      byte_out,
  output logic                           eq
);

  logic [smc_pkg::BYTE_W-1:0] held;
  logic [smc_pkg::LEN_W-1:0]  k_full;
  logic [2:0]                 k;
  logic                       en;
  logic [smc_pkg::BYTE_W-1:0] nb;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= byte_in;
    end
  end

  // this cell holds the byte IDX steps back, matched to needle byte len-1-IDX
  always_comb begin
    k_full = ncfg.len - smc_pkg::LEN_W'(IDX) - smc_pkg::LEN_W'(1);
    k      = k_full[2:0];
    en     = smc_pkg::LEN_W'(IDX) < ncfg.len;
    nb     = ncfg.bytes[k * smc_pkg::BYTE_W +: smc_pkg::BYTE_W];
    eq     = (held == nb) || !en;
  end

  assign byte_out = held;

endmodule

`default_nettype wire

FILE: src/substring_match_counter_core.sv
// path: the last item passes the first stage, then its result enters the output register
// throughput: one byte item per clock unless a last item waits on a full output register;
//   cells compare bytes combinationally; the accumulate stage takes one item per cycle
// reset: synchronous, clears the needle registers (length 1), the counters and both stages;
//   no clearing pass, items are taken as soon as reset is released
`default_nettype none

module substring_match_counter_core #(
  parameter int MAX_NEEDLE = 8,
  parameter int POS_BITS   = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [smc_pkg::IN_TDATA_W-1:0]    s_tdata,   // data_byte
  input  wire logic                              s_tlast,   // end_of_text
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // match_count, first_pos, last_pos, overflow, zero pad
  output logic [smc_pkg::OUT_TDATA_W-1:0]        m_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [smc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [smc_pkg::NEEDLE_W-1:0]      cfg_data
);

  localparam int PW = (POS_BITS > smc_pkg::FIELD_W) ? POS_BITS : smc_pkg::FIELD_W;

  // configuration
  logic [smc_pkg::NEEDLE_W-1:0] needle_q;
  logic [smc_pkg::LEN_W-1:0]    nlen_q;
  logic [smc_pkg::LEN_W-1:0]    len_eff;
  logic [smc_pkg::LEN_W-1:0]    len_m1;
  smc_pkg::needle_cfg_t         ncfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_q <= '0;
      nlen_q   <= smc_pkg::LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        smc_pkg::REG_NEEDLE_BYTES: needle_q <= cfg_data;
        smc_pkg::REG_NEEDLE_LEN:   nlen_q   <= cfg_data[smc_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (nlen_q == '0) begin
      len_eff = smc_pkg::LEN_W'(1);
    end else if (nlen_q > smc_pkg::LEN_W'(MAX_NEEDLE)) begin
      len_eff = smc_pkg::LEN_W'(MAX_NEEDLE);
    end else begin
      len_eff = nlen_q;
    end
    len_m1     = len_eff - smc_pkg::LEN_W'(1);
    ncfg.bytes = needle_q;
    ncfg.len   = len_eff;
  end

  // handshake
  logic s_accept;
  logic s1_valid;
  logic s1_last;
  logic s2_go;

  assign s_accept = s_tvalid && s_tready;
  assign s2_go    = s1_valid && (!s1_last || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || s2_go;

  // position counter, saturates one past the largest index
  logic [POS_BITS:0]   pos;
  logic                pos_sat;
  logic [POS_BITS-1:0] idx;
  logic                avail;
  logic [POS_BITS-1:0] start;

  always_comb begin
    pos_sat = pos[POS_BITS];
    idx     = pos_sat ? '1 : pos[POS_BITS-1:0];
    avail   = pos >= (POS_BITS + 1)'(len_m1);
    start   = (idx >= POS_BITS'(len_m1)) ? idx - POS_BITS'(len_m1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (s_accept) begin
      if (s_tlast) begin
        pos <= '0;
      end else if (!pos_sat) begin
        pos <= pos + (POS_BITS + 1)'(1);
      end
    end
  end

  // first stage: window cells plus the item's position info
  logic                s1_avail;
  logic                s1_range;
  logic [POS_BITS-1:0] s1_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (s2_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_last  <= s_tlast;
      s1_avail <= avail;
      s1_range <= pos_sat;
      s1_start <= start;
    end
  end

  logic [smc_pkg::BYTE_W-1:0] chain [MAX_NEEDLE];
  logic [MAX_NEEDLE-1:0]      cell_eq;

  for (genvar i = 0; i < MAX_NEEDLE; i++) begin : g_cell
    if (i == 0) begin : g_head
      smc_cell #(.IDX(i)) u_cell (
        .clk      (clk),
        .shift    (s_accept),
        .byte_in  (s_tdata[smc_pkg::BYTE_W-1:0]),
        .ncfg     (ncfg),
        .byte_out (chain[i]),
        .eq       (cell_eq[i])
      );
    end else begin : g_body
      smc_cell #(.IDX(i)) u_cell (
        .clk      (clk),
        .shift    (s_accept),
        .byte_in  (chain[i-1]),
        .ncfg     (ncfg),
        .byte_out (chain[i]),
        .eq       (cell_eq[i])
      );
    end
  end

  // second stage: accumulate matches
  logic                         hit;
  logic [smc_pkg::COUNT_W-1:0]  cnt, cnt_next;
  logic                         found, found_next;
  logic [POS_BITS-1:0]          first_q, first_next;
  logic [POS_BITS-1:0]          last_q, last_next;
  logic                         rexc, rexc_next;

  always_comb begin
    hit        = s1_avail && (&cell_eq);
    cnt_next   = cnt;
    found_next = found;
    first_next = first_q;
    last_next  = last_q;
    rexc_next  = rexc || s1_range;
    if (hit) begin
      if (cnt == smc_pkg::COUNT_MAX) begin
        rexc_next = 1'b1;
      end else begin
        cnt_next = cnt + smc_pkg::COUNT_W'(1);
      end
      if (!found) begin
        first_next = s1_start;
      end
      last_next  = s1_start;
      found_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      found <= 1'b0;
      rexc  <= 1'b0;
    end else if (s2_go) begin
      if (s1_last) begin
        cnt   <= '0;
        found <= 1'b0;
        rexc  <= 1'b0;
      end else begin
        cnt   <= cnt_next;
        found <= found_next;
        rexc  <= rexc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      first_q <= first_next;
      last_q  <= last_next;
    end
  end

  // result fields, start indices clamped to the field range
  logic [PW-1:0]               first_ext, last_ext;
  logic                        clamp_f, clamp_l;
  logic [smc_pkg::FIELD_W-1:0] first_fld, last_fld;
  logic                        ovf_fld;

  always_comb begin
    first_ext = PW'(first_next);
    last_ext  = PW'(last_next);
    clamp_f   = first_ext > PW'(smc_pkg::FIELD_POS_MAX);
    clamp_l   = last_ext > PW'(smc_pkg::FIELD_POS_MAX);
    if (!found_next) begin
      first_fld = smc_pkg::NONE_POS;
      last_fld  = smc_pkg::NONE_POS;
    end else begin
      first_fld = clamp_f ? smc_pkg::FIELD_POS_MAX : first_ext[smc_pkg::FIELD_W-1:0];
      last_fld  = clamp_l ? smc_pkg::FIELD_POS_MAX : last_ext[smc_pkg::FIELD_W-1:0];
    end
    ovf_fld = rexc_next || (found_next && (clamp_f || clamp_l));
  end

  // output register
  logic [smc_pkg::COUNT_W-1:0] o_count;
  logic [smc_pkg::FIELD_W-1:0] o_first, o_last;
  logic                        o_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_go && s1_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s1_last) begin
      o_count <= cnt_next;
      o_first <= first_fld;
      o_last  <= last_fld;
      o_ovf   <= ovf_fld;
    end
  end

  assign m_tdata = {{smc_pkg::OUT_PAD_W{1'b0}}, o_ovf, o_last, o_first, o_count};

endmodule

`default_nettype wire

FILE: src/smc_checker.sv
`default_nettype none
`include "assert_macros.svh"

module smc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic                           s_tlast,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [smc_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int CW = smc_pkg::COUNT_W;
  localparam int FW = smc_pkg::FIELD_W;

  logic [CW-1:0] r_count;
  logic [FW-1:0] r_first;
  logic [FW-1:0] r_last;
  logic          s_last_acc;

  assign r_count    = m_tdata[CW-1:0];
  assign r_first    = m_tdata[CW+FW-1:CW];
  assign r_last     = m_tdata[CW+2*FW-1:CW+FW];
  assign s_last_acc = s_tvalid && s_tready && s_tlast;

  `ASSERT_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `ASSERT_NEXT(a_hold_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))
  `ASSERT_NEXT_ALL(a_reset_idle, clk, rst, !m_tvalid)
  // a fresh result always traces to a last item taken by the first stage
  `ASSERT_IMPL(a_result_src, clk, rst, $rose(m_tvalid), $past(s_last_acc, 2))
  // no match means count zero and both indices none, else first not after last
  `ASSERT_IMPL(a_result_cons, clk, rst, m_tvalid,
    ((r_count == '0) == (r_first == smc_pkg::NONE_POS)) &&
    ((r_first == smc_pkg::NONE_POS) == (r_last == smc_pkg::NONE_POS)) &&
    ((r_first == smc_pkg::NONE_POS) || (r_first <= r_last)))

endmodule

bind substring_match_counter_core smc_checker u_smc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: bench/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_NEEDLE = 8;
  localparam int unsigned POS_MAX = (1 << 16) - 1;

  typedef struct packed {
    logic                        ovf;
    logic [smc_pkg::FIELD_W-1:0] last_start;
    logic [smc_pkg::FIELD_W-1:0] first_start;
    logic [smc_pkg::COUNT_W-1:0] count;
  } match_tally_t;

  class match_scoreboard;
    bit [smc_pkg::NEEDLE_W-1:0] needle;
    bit [smc_pkg::LEN_W-1:0]    needle_len;
    bit [7:0]                   recent[MAX_NEEDLE-1];
    int unsigned                pos;
    int unsigned                hits;
    int                         first_hit;
    int                         last_hit;
    bit                         range_hit;
    match_tally_t               pending_tallies[$];
    int unsigned                mismatches;
    int unsigned                tallies_seen;
    int unsigned                bytes_seen;

    function new();
      needle = '0;
      needle_len = 1;
      clear_text();
    endfunction

    function void clear_text();
      foreach (recent[i]) recent[i] = 8'h00;
      pos = 0;
      hits = 0;
      first_hit = -1;
      last_hit = -1;
      range_hit = 1'b0;
    endfunction

    function void set_reg(logic [smc_pkg::CFG_IDX_W-1:0] idx,
                          logic [smc_pkg::NEEDLE_W-1:0] val);
      if (idx == smc_pkg::REG_NEEDLE_BYTES) begin
        needle = val;
      end else begin
        needle_len = val[smc_pkg::LEN_W-1:0];
      end
    endfunction

    function int unsigned used_len();
      if (needle_len < 1) return 1;
      if (needle_len > MAX_NEEDLE) return MAX_NEEDLE;
      return needle_len;
    endfunction

    function logic [smc_pkg::FIELD_W-1:0] start_field(int p);
      if (p < 0) return smc_pkg::NONE_POS;
      if (p > 65535) begin
        range_hit = 1'b1;
        return smc_pkg::FIELD_POS_MAX;
      end
      return smc_pkg::FIELD_W'(p);
    endfunction

    // advance the text state by one byte, queue a tally on the end mark
    function void note_item(bit [7:0] b, bit eot);
      int unsigned  len;
      int unsigned  idx;
      int unsigned  back;
      int           start;
      bit           hit;
      bit [7:0]     hay;
      match_tally_t t;
      len = used_len();
      bytes_seen++;
      idx = pos;
      if (idx > POS_MAX) begin
        range_hit = 1'b1;
        idx = POS_MAX;
      end
      hit = (pos + 1 >= len);
      for (int k = 0; k < len; k++) begin
        back = len - 1 - k;
        hay = (back == 0) ? b : recent[back-1];
        if (hay != needle[k*8 +: 8]) hit = 1'b0;
      end
      if (hit) begin
        start = (idx >= len - 1) ? int'(idx - (len - 1)) : 0;
        if (hits >= smc_pkg::COUNT_MAX) range_hit = 1'b1;
        else hits++;
        if (first_hit < 0) first_hit = start;
        last_hit = start;
      end
      for (int i = MAX_NEEDLE - 2; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = b;
      if (pos <= POS_MAX) pos++;
      if (eot) begin
        t.count = smc_pkg::COUNT_W'(hits);
        t.first_start = start_field(first_hit);
        t.last_start = start_field(last_hit);
        t.ovf = range_hit;
        pending_tallies.push_back(t);
        clear_text();
      end
    endfunction

    function void flag(string what, logic [50:0] want, logic [50:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s at %0t: expected %0h, got %0h", what, $time, want, got);
    endfunction

    function void check_result(logic [smc_pkg::OUT_TDATA_W-1:0] d);
      match_tally_t want;
      if (pending_tallies.size() == 0) begin
        flag("unexpected result", '0, d[50:0]);
        return;
      end
      want = pending_tallies.pop_front();
      tallies_seen++;
      if (d[15:0] !== want.count) flag("match_count", want.count, d[15:0]);
      if (d[32:16] !== want.first_start) flag("first_pos", want.first_start, d[32:16]);
      if (d[49:33] !== want.last_start) flag("last_pos", want.last_start, d[49:33]);
      if (d[50] !== want.ovf) flag("overflow", want.ovf, d[50]);
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [smc_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            s_tlast = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [smc_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            cfg_we = 1'b0;
  logic [smc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [smc_pkg::NEEDLE_W-1:0]    cfg_data = '0;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  match_scoreboard sb = new();

  substring_match_counter_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_item(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  task automatic send_byte(bit [7:0] b, bit eot);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= eot;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_bytes(bit [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic send_run(bit [7:0] b, int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_byte(b, i == n - 1);
  endtask

  // stop sending and let every outstanding tally come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_tallies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_needle(bit [smc_pkg::NEEDLE_W-1:0] bytes,
                              bit [smc_pkg::LEN_W-1:0] len);
    cfg_we <= 1'b1;
    cfg_index <= smc_pkg::REG_NEEDLE_BYTES;
    cfg_data <= bytes;
    sb.set_reg(smc_pkg::REG_NEEDLE_BYTES, bytes);
    @(posedge clk);
    cfg_index <= smc_pkg::REG_NEEDLE_LEN;
    cfg_data <= smc_pkg::NEEDLE_W'(len);
    sb.set_reg(smc_pkg::REG_NEEDLE_LEN, smc_pkg::NEEDLE_W'(len));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // small alphabet so that texts built from it hit often
  task automatic random_needle();
    bit [smc_pkg::NEEDLE_W-1:0] nb;
    bit [smc_pkg::LEN_W-1:0]    len;
    for (int k = 0; k < MAX_NEEDLE; k++)
      nb[k*8 +: 8] = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                               : 8'(8'h41 + $urandom_range(2));
    len = ($urandom_range(5) == 0) ? smc_pkg::LEN_W'($urandom_range(15))
                                   : smc_pkg::LEN_W'($urandom_range(1, 8));
    write_needle(nb, len);
  endtask

  // text of n bytes made of needle copies, prefixes, needle letters and noise
  task automatic send_text(int unsigned n);
    bit [7:0]    q[$];
    int unsigned len;
    int unsigned cnt;
    int unsigned r;
    len = sb.used_len();
    while (q.size() < n) begin
      r = $urandom_range(9);
      if (r < 4) begin
        cnt = $urandom_range(1) ? len : $urandom_range(1, len);
        for (int k = 0; k < cnt; k++) q.push_back(sb.needle[k*8 +: 8]);
      end else if (r < 8) begin
        q.push_back(sb.needle[$urandom_range(len - 1)*8 +: 8]);
      end else begin
        q.push_back(8'($urandom_range(255)));
      end
    end
    while (q.size() > n) void'(q.pop_back());
    send_bytes(q);
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // after reset the needle is a single zero byte
    send_byte(8'h00, 1'b1);
    drain();
    // length above the maximum acts as eight
    write_needle('1, 15);
    send_run(8'hFF, 8);
    drain();
    // length zero acts as one, overlapping hits on every byte
    write_needle(64'hDEAD_BEEF_CAFE_F041, 0);
    send_run(8'h41, 3);
    drain();
    // overlapping hits, junk above the length ignored
    write_needle(64'hFFFF_FFFF_FF41_4241, 3);
    send_bytes('{8'h41, 8'h42, 8'h41, 8'h42, 8'h41});
    drain();
    // text shorter than the needle
    write_needle(64'h0000_0000_4443_4241, 4);
    send_bytes('{8'h41, 8'h42});
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 84; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 84; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      random_needle();
      sent = 0;
      while (sent < 230) begin
        n = ($urandom_range(15) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
        send_text(n);
        sent += n;
        if ($urandom_range(19) == 0) begin
          drain();
          random_needle();
        end
      end
      drain();
    end

    $display("checked %0d tallies over %0d text bytes: needle lengths 0 to 15,",
             sb.tallies_seen, sb.bytes_seen);
    $display("short directed texts, random needles under four handshake mixes");
    if (sb.mismatches == 0 && sb.pending_tallies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
